>>> hw/rtl/sbcf_pkg.sv
// Shared types, codes and helper functions for the SPI burst command framer.
package sbcf_pkg;

   localparam int ADDR_W      = 26;
   localparam int WADDR_W     = 24;
   localparam int LEN_W       = 17;
   localparam int CHUNK_W     = 9;
   localparam int POS_W       = 9;
   localparam int PAD_W       = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [1:0] FUNC_BEGIN = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [1:0] KIND_LINK = 2'd0;
   localparam logic [1:0] KIND_PAD  = 2'd1;
   localparam logic [1:0] KIND_HOST = 2'd2;

   localparam logic [7:0] CMD_WRITE = 8'h80;
   localparam logic [7:0] CMD_READ  = 8'h60;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_WRITE = 3'b010,
      MODE_READ  = 3'b100
   } mode_type;

   typedef struct packed {
      logic [1:0]        func;
      logic              is_write;
      logic [ADDR_W-1:0] byte_addr;
      logic [LEN_W-1:0]  length;
      logic [7:0]        data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       out_byte;
      logic [PAD_W-1:0] pad_count;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic               has_byte;
      logic [1:0]         byte_kind;
      logic [7:0]         byte_val;
      logic               byte_last;
      logic               has_pad;
      logic [PAD_W-1:0]   pad_count;
      logic               has_hdr;
      logic [7:0]         cmd;
      logic [WADDR_W-1:0] word_addr;
      logic               hdr_last;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } q_wr_type;

   typedef struct packed {
      logic    valid;
      logic    full;
      job_type job;
   } q_rd_type;

   function automatic logic [CHUNK_W-1:0] pad_up(input logic [CHUNK_W-1:0] n);
      logic [CHUNK_W-1:0] p;
      if (n <= 9'd4) p = 9'd4;
      else if (n <= 9'd16) p = 9'd16;
      else if (n <= 9'd32) p = 9'd32;
      else if (n <= 9'd64) p = 9'd64;
      else if (n <= 9'd128) p = 9'd128;
      else p = 9'd256;
      return p;
   endfunction

   function automatic logic [2:0] size_code(input logic [CHUNK_W-1:0] p);
      logic [2:0] c;
      case (p)
         9'd4:    c = 3'd0;
         9'd16:   c = 3'd1;
         9'd32:   c = 3'd2;
         9'd64:   c = 3'd3;
         9'd128:  c = 3'd4;
         default: c = 3'd5;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/spi_burst_command_framer_unit.sv
// Top level of the SPI burst command framer.
// Takes one request beat per cycle while the four-entry job queue has room.
// A begin beat yields the four header bytes of the first chunk, a payload
// beat yields its byte and, at the end of a chunk, the padding run and the
// next header (up to six results), and a response beat yields at most one
// host byte plus the next header. The result sequencer sends one response
// beat per cycle while rsp_stall is low; a beat with n results keeps it
// busy until all are sent; each result is queued, then registered for output.
// req_stall rises only when the job queue is full.
module spi_burst_command_framer_unit #(
   parameter int CHUNK_BYTES  = 256,
   parameter int MAX_TRANSFER = 65536,
   parameter int DUMMY_BYTES  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sbcf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sbcf_pkg::rsp_type rsp_data
);
   import sbcf_pkg::*;

   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     pop;

   sbcf_front #(
      .CHUNK_BYTES  (CHUNK_BYTES),
      .MAX_TRANSFER (MAX_TRANSFER),
      .DUMMY_BYTES  (DUMMY_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_rd.full),
      .q_wr      (q_wr)
   );

   sbcf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (pop),
      .q_rd  (q_rd)
   );

   sbcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rd      (q_rd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = q_rd.full;

endmodule

>>> hw/rtl/sbcf_front.sv
// Front end: accepts request beats, tracks transfer state and builds result jobs.
module sbcf_front #(
   parameter int CHUNK_BYTES  = 256,
   parameter int MAX_TRANSFER = 65536,
   parameter int DUMMY_BYTES  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  sbcf_pkg::req_type req_data,
   input  logic              q_full,
   output sbcf_pkg::q_wr_type q_wr
);
   import sbcf_pkg::*;

   localparam int RW = $clog2(MAX_TRANSFER + 1);
   localparam int SW = 21;

   mode_type           mode_ff, mode_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [CHUNK_W-1:0] padded_ff, padded_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   logic               accept;
   logic [CHUNK_W-1:0] pad;
   logic [POS_W-1:0]   pos_n;
   logic [RW-1:0]      rem_dec;
   logic [RW-1:0]      rem_rd;
   logic [ADDR_W-1:0]  addr_adv;
   logic [SW-1:0]      len_ext;
   logic               do_start;
   logic [RW-1:0]      hdr_rem;
   logic [ADDR_W-1:0]  hdr_addr;
   logic               hdr_rd;
   logic               rd_data;
   job_type            job;

   assign accept   = req_valid && !q_full;
   assign pad      = padded_ff - chunk_ff;
   assign pos_n    = pos_ff + POS_W'(1);
   assign rem_dec  = rem_ff - RW'(1);
   assign addr_adv = addr_ff + ADDR_W'(CHUNK_BYTES);
   assign len_ext  = SW'(req_data.length);
   assign rd_data  = ({1'b0, pos_ff} >= (POS_W + 1)'(DUMMY_BYTES))
                  && ({1'b0, pos_ff} < (POS_W + 1)'(DUMMY_BYTES) + {1'b0, chunk_ff})
                  && (rem_ff != '0);
   assign rem_rd   = rd_data ? rem_dec : rem_ff;

   always_comb begin
      mode_in   = mode_ff;
      addr_in   = addr_ff;
      rem_in    = rem_ff;
      chunk_in  = chunk_ff;
      padded_in = padded_ff;
      pos_in    = pos_ff;
      do_start  = 1'b0;
      hdr_rem   = rem_ff;
      hdr_addr  = addr_ff;
      hdr_rd    = 1'b0;
      job       = '0;
      if (accept) begin
         unique case (mode_ff)
            MODE_WRITE: begin
               if (req_data.func == FUNC_WRITE) begin
                  pos_in        = pos_n;
                  rem_in        = rem_dec;
                  job.has_byte  = 1'b1;
                  job.byte_kind = KIND_LINK;
                  job.byte_val  = req_data.data_byte;
                  job.byte_last = (pos_n == chunk_ff) && (pad == '0);
                  if (pos_n == chunk_ff) begin
                     job.has_pad   = (pad != '0);
                     job.pad_count = pad[PAD_W-1:0];
                     addr_in       = addr_adv;
                     if (rem_dec != '0) begin
                        do_start = 1'b1;
                        hdr_rem  = rem_dec;
                        hdr_addr = addr_adv;
                        hdr_rd   = 1'b0;
                     end else begin
                        mode_in = MODE_IDLE;
                     end
                  end
               end
            end
            MODE_READ: begin
               if (req_data.func == FUNC_READ) begin
                  pos_in        = pos_n;
                  rem_in        = rem_rd;
                  job.has_byte  = rd_data;
                  job.byte_kind = KIND_HOST;
                  job.byte_val  = req_data.data_byte;
                  job.byte_last = (rem_dec == '0);
                  if ({1'b0, pos_n} >=
                      (POS_W + 1)'(DUMMY_BYTES) + {1'b0, padded_ff}) begin
                     addr_in = addr_adv;
                     if (rem_rd != '0) begin
                        do_start = 1'b1;
                        hdr_rem  = rem_rd;
                        hdr_addr = addr_adv;
                        hdr_rd   = 1'b1;
                     end else begin
                        mode_in = MODE_IDLE;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (req_data.func == FUNC_BEGIN && req_data.length != '0) begin
            do_start = 1'b1;
            hdr_rem  = (len_ext > SW'(MAX_TRANSFER)) ? RW'(MAX_TRANSFER) : RW'(len_ext);
            hdr_addr = req_data.byte_addr;
            hdr_rd   = !req_data.is_write;
            mode_in  = req_data.is_write ? MODE_WRITE : MODE_READ;
            job      = '0;
         end
      end
      if (do_start) begin
         chunk_in     = (hdr_rem < RW'(CHUNK_BYTES)) ? hdr_rem[CHUNK_W-1:0]
                                                     : CHUNK_W'(CHUNK_BYTES);
         padded_in    = pad_up(chunk_in);
         pos_in       = '0;
         rem_in       = hdr_rem;
         addr_in      = hdr_addr;
         job.has_hdr  = 1'b1;
         job.cmd      = (hdr_rd ? CMD_READ : CMD_WRITE) | {5'b0, size_code(padded_in)};
         job.word_addr = hdr_addr[ADDR_W-1:2];
         job.hdr_last = hdr_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         addr_ff   <= '0;
         rem_ff    <= '0;
         chunk_ff  <= '0;
         padded_ff <= '0;
         pos_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         addr_ff   <= addr_in;
         rem_ff    <= rem_in;
         chunk_ff  <= chunk_in;
         padded_ff <= padded_in;
         pos_ff    <= pos_in;
      end
   end

   assign q_wr.push = accept && (job.has_byte || job.has_pad || job.has_hdr);
   assign q_wr.job  = job;

endmodule

>>> hw/rtl/sbcf_queue.sv
// Short job queue between the front end and the result sequencer.
module sbcf_queue (
   input  logic               clock,
   input  logic               reset,
   input  sbcf_pkg::q_wr_type q_wr,
   input  logic               pop,
   output sbcf_pkg::q_rd_type q_rd
);
   import sbcf_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign wr_ptr_in = q_wr.push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + (QPTR_W + 1)'(q_wr.push) - (QPTR_W + 1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push) begin
         entry_ff[wr_ptr_ff] <= q_wr.job;
      end
   end

   assign q_rd.valid = (count_ff != '0);
   assign q_rd.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign q_rd.job   = entry_ff[rd_ptr_ff];

endmodule

>>> hw/rtl/sbcf_back.sv
// Back end: walks each queued job, one response beat per unstalled cycle.
module sbcf_back (
   input  logic               clock,
   input  logic               reset,
   input  sbcf_pkg::q_rd_type q_rd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sbcf_pkg::rsp_type  rsp_data
);
   import sbcf_pkg::*;

   logic       started_ff, started_in;
   logic [5:0] mask_ff, mask_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;

   logic [5:0] slots;
   logic [5:0] rem_mask;
   logic [5:0] low;
   logic [5:0] next_mask;
   logic       load;

   assign slots     = {{4{q_rd.job.has_hdr}}, q_rd.job.has_pad, q_rd.job.has_byte};
   assign rem_mask  = started_ff ? mask_ff : slots;
   assign low       = rem_mask & (~rem_mask + 6'd1);
   assign next_mask = rem_mask & ~low;
   assign load      = q_rd.valid && (!valid_ff || !rsp_stall);
   assign pop       = load && (next_mask == '0);

   always_comb begin
      data_in = '0;
      case (low)
         6'b000001: begin
            data_in.kind     = q_rd.job.byte_kind;
            data_in.out_byte = q_rd.job.byte_val;
            data_in.last     = q_rd.job.byte_last;
         end
         6'b000010: begin
            data_in.kind      = KIND_PAD;
            data_in.pad_count = q_rd.job.pad_count;
            data_in.last      = 1'b1;
         end
         6'b000100: begin
            data_in.kind     = KIND_LINK;
            data_in.out_byte = q_rd.job.cmd;
         end
         6'b001000: begin
            data_in.kind     = KIND_LINK;
            data_in.out_byte = q_rd.job.word_addr[23:16];
         end
         6'b010000: begin
            data_in.kind     = KIND_LINK;
            data_in.out_byte = q_rd.job.word_addr[15:8];
         end
         6'b100000: begin
            data_in.kind     = KIND_LINK;
            data_in.out_byte = q_rd.job.word_addr[7:0];
            data_in.last     = q_rd.job.hdr_last;
         end
         default: data_in = '0;
      endcase
   end

   assign valid_in   = load ? 1'b1 : (valid_ff && rsp_stall);
   assign started_in = load ? (next_mask != '0) : started_ff;
   assign mask_in    = load ? next_mask : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         mask_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         mask_ff    <= mask_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> hw/rtl/sbcf_checker.sv
// Port-level checks on the framer's response channel, bound to the top level.
module sbcf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sbcf_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sbcf_pkg::rsp_type rsp_data
);
   import sbcf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind == KIND_LINK) || (rsp_data.kind == KIND_PAD)
                 || (rsp_data.kind == KIND_HOST))
      else $error("illegal response kind");

   a_pad_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_PAD) |->
         rsp_data.last && (rsp_data.out_byte == 8'd0) && (rsp_data.pad_count != '0))
      else $error("malformed padding run");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_PAD) |-> (rsp_data.pad_count == '0))
      else $error("pad count on a byte beat");

   a_begin_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.func == FUNC_BEGIN)
         && (req_data.length != '0) |-> ##2 rsp_valid)
      else $error("begin beat gave no response beat");

endmodule

bind spi_burst_command_framer_unit sbcf_checker u_checker (.*);

>>> tb/sbcf_frame_checker.sv
// Checker for the SPI burst command framer: predicts framed bytes from request beats and compares.
module sbcf_frame_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  sbcf_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  sbcf_pkg::rsp_type rsp_data,
   output int                fault_count,
   output int                pending
);
   import sbcf_pkg::*;

   localparam int CHUNK   = 256;
   localparam int MAX_LEN = 65536;
   localparam int DUMMY   = 4;

   mode_type    run_mode;
   logic [23:0] waddr;
   logic [1:0]  alow;
   logic [16:0] remaining;
   logic [8:0]  csize;
   logic [8:0]  psize;
   logic [8:0]  cpos;
   rsp_type     bytes_due[$];

   function automatic logic [8:0] round_up(input logic [8:0] n);
      logic [8:0] p;
      p = 9'd4;
      if (n > 9'd4) begin
         p = 9'd16;
         while (p < n) p = p << 1;
      end
      return p;
   endfunction

   function automatic logic [2:0] size_bits(input logic [8:0] p);
      logic [2:0] c;
      c = 3'd0;
      for (int i = 4; i <= 8; i++)
         if (p[i]) c = 3'(i - 3);
      return c;
   endfunction

   task automatic add_due(input logic [1:0] kind, input logic [7:0] value,
                          input logic [6:0] pad, input logic last);
      rsp_type r;
      r.kind      = kind;
      r.out_byte  = value;
      r.pad_count = pad;
      r.last      = last;
      bytes_due.push_back(r);
   endtask

   task automatic open_chunk();
      logic [7:0] cmd;
      csize = (remaining < CHUNK) ? remaining[8:0] : 9'(CHUNK);
      psize = round_up(csize);
      cpos  = '0;
      cmd   = ((run_mode == MODE_READ) ? CMD_READ : CMD_WRITE) | 8'(size_bits(psize));
      add_due(KIND_LINK, cmd, '0, 1'b0);
      add_due(KIND_LINK, waddr[23:16], '0, 1'b0);
      add_due(KIND_LINK, waddr[15:8], '0, 1'b0);
      add_due(KIND_LINK, waddr[7:0], '0, run_mode == MODE_READ);
   endtask

   task automatic close_chunk();
      logic [25:0] full;
      full  = {waddr, alow} + 26'(CHUNK);
      waddr = full[25:2];
      alow  = full[1:0];
      if (remaining != 0) open_chunk();
      else run_mode = MODE_IDLE;
   endtask

   task automatic frame_request(input req_type r);
      logic [16:0] len;
      logic [8:0]  pad;
      logic [8:0]  p;
      case (r.func)
         FUNC_BEGIN: begin
            if (r.length != 0) begin
               len       = (r.length > MAX_LEN) ? 17'(MAX_LEN) : r.length;
               run_mode  = r.is_write ? MODE_WRITE : MODE_READ;
               waddr     = r.byte_addr[25:2];
               alow      = r.byte_addr[1:0];
               remaining = len;
               open_chunk();
            end
         end
         FUNC_WRITE: begin
            if (run_mode == MODE_WRITE) begin
               pad = psize - csize;
               cpos++;
               remaining--;
               add_due(KIND_LINK, r.data_byte, '0, cpos == csize && pad == 0);
               if (cpos == csize) begin
                  if (pad != 0) add_due(KIND_PAD, 8'h00, pad[6:0], 1'b1);
                  close_chunk();
               end
            end
         end
         FUNC_READ: begin
            if (run_mode == MODE_READ) begin
               p = cpos;
               cpos++;
               if (p >= DUMMY && p < DUMMY + csize && remaining != 0) begin
                  remaining--;
                  add_due(KIND_HOST, r.data_byte, '0, remaining == 0);
               end
               if (cpos >= DUMMY + psize) close_chunk();
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         run_mode    = MODE_IDLE;
         waddr       = '0;
         alow        = '0;
         remaining   = '0;
         csize       = '0;
         psize       = '0;
         cpos        = '0;
         fault_count = 0;
         bytes_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bytes_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected beat: kind=%0d byte=%02h pad=%0d last=%0b",
                           rsp_data.kind, rsp_data.out_byte, rsp_data.pad_count,
                           rsp_data.last);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
                   rsp_data.pad_count !== want.pad_count || rsp_data.last !== want.last) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("beat mismatch: expected kind=%0d byte=%02h pad=%0d last=%0b, %s",
                              want.kind, want.out_byte, want.pad_count, want.last,
                              $sformatf("got kind=%0d byte=%02h pad=%0d last=%0b",
                                        rsp_data.kind, rsp_data.out_byte,
                                        rsp_data.pad_count, rsp_data.last));
               end
            end
         end
         if (req_valid && !req_stall) frame_request(req_data);
      end
      pending <= bytes_due.size();
   end

endmodule

>>> tb/tb_spi_burst_command_framer_unit.sv
// Testbench top for the SPI burst command framer: clock, reset, request and stall stimulus, verdict.
module tb_spi_burst_command_framer_unit;
   import sbcf_pkg::*;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int WORK_ITEMS   = 450;
   localparam int QUIET_TAIL   = 380;
   localparam int DRAIN_CYCLES = 24;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   int          fault_count;
   int          pending;
   int unsigned cycle_count = 0;
   logic        gaps_on = 1'b0;
   logic        stall_on = 1'b0;
   int          work_items = 0;

   always #1 clock = ~clock;

   spi_burst_command_framer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sbcf_frame_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fault_count (fault_count),
      .pending     (pending)
   );

   function automatic req_type make_beat(input logic [1:0] func, input logic is_write,
                                         input logic [25:0] addr, input logic [16:0] len,
                                         input logic [7:0] value);
      req_type r;
      r.func      = func;
      r.is_write  = is_write;
      r.byte_addr = addr;
      r.length    = len;
      r.data_byte = value;
      return r;
   endfunction

   function automatic req_type data_beat(input logic [1:0] func);
      return make_beat(func, 1'($urandom), 26'($urandom), 17'($urandom), 8'($urandom));
   endfunction

   function automatic req_type noise_beat();
      req_type r;
      r = data_beat(FUNC_NONE);
      case ($urandom_range(0, 2))
         0: r.func = FUNC_NONE;
         1: begin
            r.func   = FUNC_BEGIN;
            r.length = '0;
         end
         default: r.func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      endcase
      return r;
   endfunction

   // link beats for a whole read: dummy bytes plus padded chunk per chunk
   function automatic int link_beats(input int len);
      int n;
      int left;
      int c;
      int p;
      n    = 0;
      left = len;
      while (left > 0) begin
         c = (left < 256) ? left : 256;
         p = 4;
         if (c > 4) begin
            p = 16;
            while (p < c) p = p * 2;
         end
         n    = n + 4 + p;
         left = left - c;
      end
      return n;
   endfunction

   task automatic send_beat(input req_type r);
      if (work_items >= QUIET_TAIL) begin
         gaps_on  = 1'b0;
         stall_on = 1'b0;
      end
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic run_transfer(input logic is_write, input logic [25:0] addr, input int len,
                               input logic broken);
      int beats;
      beats = is_write ? len : link_beats(len);
      if (broken) beats = $urandom_range(0, beats);
      send_beat(make_beat(FUNC_BEGIN, is_write, addr, 17'(len), 8'($urandom)));
      work_items++;
      if (beats > WORK_ITEMS - work_items) beats = WORK_ITEMS - work_items;
      repeat (beats) begin
         send_beat(data_beat(is_write ? FUNC_WRITE : FUNC_READ));
         work_items++;
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("spi_burst_command_framer_unit test failed");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      gaps_on  = 1'b1;
      stall_on = 1'b1;
      // single-byte write with a padding run
      send_beat(make_beat(FUNC_BEGIN, 1'b1, '0, 17'd1, 8'h00));
      send_beat(make_beat(FUNC_WRITE, 1'b0, '0, '0, 8'h00));
      // read at the top address
      send_beat(make_beat(FUNC_BEGIN, 1'b0, '1, 17'd4, 8'hff));
      repeat (8) send_beat(make_beat(FUNC_READ, 1'b1, '1, '1, 8'hff));
      // drop bytes that arrive while idle, the unused function and a zero-length begin
      send_beat(make_beat(FUNC_WRITE, 1'b1, '1, '1, 8'h5a));
      send_beat(make_beat(FUNC_READ, 1'b0, '0, '0, 8'ha5));
      send_beat(make_beat(FUNC_NONE, 1'b1, '1, '1, 8'hff));
      send_beat(make_beat(FUNC_BEGIN, 1'b1, 26'h2aaaaaa, 17'd0, 8'h00));
      // saturate, abandon, then drop a payload byte in a read
      send_beat(make_beat(FUNC_BEGIN, 1'b1, 26'h1555555, '1, 8'h00));
      send_beat(make_beat(FUNC_BEGIN, 1'b0, 26'h0000103, 17'h10000, 8'h00));
      send_beat(make_beat(FUNC_WRITE, 1'b0, '0, '0, 8'h3c));
      send_beat(make_beat(FUNC_NONE, 1'b0, '0, '0, 8'h00));
      // exact fill, no padding
      send_beat(make_beat(FUNC_BEGIN, 1'b1, 26'h3ffff01, 17'd4, 8'h00));
      repeat (4) send_beat(make_beat(FUNC_WRITE, 1'b0, '0, '0, 8'hff));

      while (work_items < WORK_ITEMS) begin
         int          sel;
         int          len;
         logic [25:0] addr;
         if (work_items >= QUIET_TAIL) begin
            gaps_on  = 1'b0;
            stall_on = 1'b0;
         end else begin
            gaps_on  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
         end
         if ($urandom_range(0, 7) == 0) begin
            send_beat(noise_beat());
            work_items++;
         end
         sel  = $urandom_range(0, 99);
         addr = 26'($urandom);
         if (sel < 65) len = $urandom_range(1, 12);
         else if (sel < 85) len = $urandom_range(13, 70);
         else if (sel < 93) begin
            // around the chunk size, crossing a boundary above 256 bytes, often wrapping the address
            len = $urandom_range(250, 262);
            if ($urandom_range(0, 1)) addr = 26'h3ffffff - 26'($urandom_range(0, 400));
         end else len = $urandom_range(1, 4);
         run_transfer(1'($urandom), addr, len, $urandom_range(0, 9) == 0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending == 0)
         $display("spi_burst_command_framer_unit test passed");
      else
         $display("spi_burst_command_framer_unit test failed");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/sbcf_pkg.sv
hw/rtl/sbcf_front.sv
hw/rtl/sbcf_queue.sv
hw/rtl/sbcf_back.sv
hw/rtl/spi_burst_command_framer_unit.sv
hw/rtl/sbcf_checker.sv
tb/sbcf_frame_checker.sv
tb/tb_spi_burst_command_framer_unit.sv
